[sv/ogne_pkg.sv]
// ----------------------------------------------------------------------------
// ogne_pkg: shared types and constants for organized grid normal estimation
// Holds the point and normal beat formats, the datapath widths, the register
// indexes, the state encodings and the small helper functions.
// ----------------------------------------------------------------------------
package ogne_pkg;

  // Grid and field widths.
  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int COORD_BITS     = 24;
  localparam int NORMAL_BITS    = 16;
  localparam int ADDR_BITS      = 10;
  localparam int DIM_BITS       = 11;
  localparam int CFG_INDEX_BITS = 1;

  // Datapath widths. Offsets from the centre stay below 2^30 for these
  // coordinate widths, so they never need the pre-shift.
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int VEC_BITS   = PROD_BITS + 1;
  localparam int UNIT_BITS  = 32;
  localparam int SUM_BITS   = UNIT_BITS + 3;
  localparam int FRAC_BITS  = 30;
  localparam int OUT_SHIFT  = FRAC_BITS - (NORMAL_BITS - 1);
  localparam int ROUND_HALF = 1 << (OUT_SHIFT - 1);
  localparam int NORM_LIM   = (1 << (NORMAL_BITS - 1)) - 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 1'd1;

  // Input beat; also the format of one stored line entry.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic                         point_valid;
  } point_t;

  // Output beat.
  typedef struct packed {
    logic signed [NORMAL_BITS-1:0] normal_x;
    logic signed [NORMAL_BITS-1:0] normal_y;
    logic signed [NORMAL_BITS-1:0] normal_z;
    logic                          has_normal;
    logic [ADDR_BITS-1:0]          normal_row;
    logic [ADDR_BITS-1:0]          normal_col;
    logic                          frame_last;
  } normal_t;

  // Request to and response from the vector normalizer.
  typedef struct packed {
    logic                       start;
    logic signed [VEC_BITS-1:0] vec_x;
    logic signed [VEC_BITS-1:0] vec_y;
    logic signed [VEC_BITS-1:0] vec_z;
  } unit_req_t;

  typedef struct packed {
    logic                        done;
    logic signed [UNIT_BITS-1:0] unit_x;
    logic signed [UNIT_BITS-1:0] unit_y;
    logic signed [UNIT_BITS-1:0] unit_z;
  } unit_rsp_t;

  // Top-level sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_PAIR,
    S_MUL,
    S_CROSS,
    S_UNIT,
    S_FINAL,
    S_FUNIT,
    S_OUT
  } state_t;

  // Normalizer states.
  typedef enum logic [2:0] {
    U_IDLE,
    U_NORM,
    U_SQ,
    U_SQRT,
    U_DIV
  } unit_state_t;

  // Window position of the k-th neighbor on the ring around the centre.
  function automatic logic [3:0] ring_pos(input logic [2:0] k);
    logic [3:0] pos;
    case (k)
      3'd0:    pos = 4'd1;
      3'd1:    pos = 4'd0;
      3'd2:    pos = 4'd3;
      3'd3:    pos = 4'd6;
      3'd4:    pos = 4'd7;
      3'd5:    pos = 4'd8;
      3'd6:    pos = 4'd5;
      default: pos = 4'd2;
    endcase
    return pos;
  endfunction

  // Signed difference of two coordinates, one bit wider.
  function automatic logic signed [DIFF_BITS-1:0] sdiff(
    input logic signed [COORD_BITS-1:0] q,
    input logic signed [COORD_BITS-1:0] p
  );
    return DIFF_BITS'(q) - DIFF_BITS'(p);
  endfunction

  // Round a 30-fraction-bit unit component to the output format, half away
  // from zero, saturating the magnitude for both signs.
  function automatic logic signed [NORMAL_BITS-1:0] to_out(
    input logic signed [UNIT_BITS-1:0] u
  );
    logic [UNIT_BITS-1:0]   mag;
    logic [UNIT_BITS-1:0]   rnd;
    logic [NORMAL_BITS-1:0] m;
    mag = u[UNIT_BITS-1] ? (~u + 1'b1) : u;
    rnd = (mag + UNIT_BITS'(ROUND_HALF)) >> OUT_SHIFT;
    if (rnd > UNIT_BITS'(NORM_LIM)) begin
      m = NORMAL_BITS'(NORM_LIM);
    end else begin
      m = rnd[NORMAL_BITS-1:0];
    end
    return u[UNIT_BITS-1] ? $signed(~m + 1'b1) : $signed(m);
  endfunction

endpackage

[sv/organized_grid_normal_estimation.sv]
// ----------------------------------------------------------------------------
// organized_grid_normal_estimation: surface normals of a raster point grid
// Keeps two line buffers and a 3x3 window, and for each valid interior
// centre sums the unit cross products of adjacent valid ring neighbors and
// normalizes the sum.
// ----------------------------------------------------------------------------
//
//  Channel   Beat            Handshake            Direction
//  in        point_t         in_valid / in_stall  into the block
//  out       normal_t        out_valid / out_stall out of the block
//  cfg       11-bit data     cfg_wr_en, cfg_index into the block
//
//  A point that gives no result goes from the load state straight back to
//  idle; an invalid interior centre goes on to the output state. A valid
//  interior centre takes up to nine normalizations by the shared normalizer,
//  with its one-digit-a-cycle square root and three 31-step divisions.
//  Reset is synchronous: counters go to zero, the window clears, the line
//  buffers stay unknown until written. The output register lets a finished
//  beat wait under out_stall while the next point is taken in.
//
module organized_grid_normal_estimation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ogne_pkg::point_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ogne_pkg::normal_t                   out_data,
  input  logic                                cfg_wr_en,
  input  logic [ogne_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ogne_pkg::DIM_BITS-1:0]       cfg_data
);

  localparam int AB = ogne_pkg::ADDR_BITS;
  localparam int DB = ogne_pkg::DIFF_BITS;
  localparam int PB = ogne_pkg::PROD_BITS;
  localparam int VB = ogne_pkg::VEC_BITS;
  localparam int SB = ogne_pkg::SUM_BITS;

  ogne_pkg::state_t state, state_next;

  logic [ogne_pkg::DIM_BITS-1:0] grid_width, grid_height;
  logic [AB-1:0]     column_count, row_count;
  logic [AB-1:0]     col_last, row_last;
  logic              last_col, last_row, accept, slot_free;

  ogne_pkg::point_t  nc, upper_q, middle_q, qa, qb, ctr;
  ogne_pkg::point_t  win [9];
  logic [AB-1:0]     idx_q, res_row, res_col;
  logic              emit_q, last_q, has_q;
  logic [2:0]        k, mcnt;
  logic              pair_ok;
  logic signed [DB-1:0] ax, ay, az, bx, by, bz, mul_a, mul_b;
  logic signed [PB-1:0] prod [6];
  logic signed [SB-1:0] sum_x, sum_y, sum_z;
  logic signed [ogne_pkg::NORMAL_BITS-1:0] res_x, res_y, res_z;
  logic              sum_zero;
  ogne_pkg::unit_req_t req;
  ogne_pkg::unit_rsp_t rsp;

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // Effective last column and row: dimensions clamp to [3, maximum].
  always_comb begin
    if (grid_width < ogne_pkg::DIM_BITS'(3)) begin
      col_last = AB'(2);
    end else if (grid_width > ogne_pkg::DIM_BITS'(ogne_pkg::MAX_WIDTH)) begin
      col_last = AB'(ogne_pkg::MAX_WIDTH - 1);
    end else begin
      col_last = AB'(grid_width - 1'b1);
    end
    if (grid_height < ogne_pkg::DIM_BITS'(3)) begin
      row_last = AB'(2);
    end else if (grid_height > ogne_pkg::DIM_BITS'(ogne_pkg::MAX_HEIGHT)) begin
      row_last = AB'(ogne_pkg::MAX_HEIGHT - 1);
    end else begin
      row_last = AB'(grid_height - 1'b1);
    end
  end

  assign last_col = column_count >= col_last;
  assign last_row = row_count >= row_last;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= ogne_pkg::DIM_BITS'(640);
      grid_height <= ogne_pkg::DIM_BITS'(480);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ogne_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
        ogne_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
        default:                   grid_width  <= grid_width;
      endcase
    end
  end

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // Point capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      nc      <= in_data;
      idx_q   <= column_count;
      emit_q  <= (row_count >= AB'(2)) && (column_count >= AB'(2));
      last_q  <= last_col && last_row;
      res_row <= row_count - 1'b1;
      res_col <= column_count - 1'b1;
    end
  end

  ogne_line_buf u_line_buf (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (column_count),
    .wr_en    (state == ogne_pkg::S_LOAD),
    .wr_addr  (idx_q),
    .wr_point (nc),
    .upper_q  (upper_q),
    .middle_q (middle_q)
  );

  // Ring pair under test.
  assign ctr     = win[4];
  assign qa      = win[ogne_pkg::ring_pos(k)];
  assign qb      = win[ogne_pkg::ring_pos(k + 3'd1)];
  assign pair_ok = qa.point_valid && qb.point_valid;

  // Multiplier operands for each cross-product term.
  always_comb begin
    case (mcnt)
      3'd0:    begin mul_a = ay; mul_b = bz; end
      3'd1:    begin mul_a = az; mul_b = by; end
      3'd2:    begin mul_a = az; mul_b = bx; end
      3'd3:    begin mul_a = ax; mul_b = bz; end
      3'd4:    begin mul_a = ax; mul_b = by; end
      default: begin mul_a = ay; mul_b = bx; end
    endcase
  end

  assign sum_zero = (sum_x == '0) && (sum_y == '0) && (sum_z == '0);

  // Normalizer request: a cross product or the final sum.
  always_comb begin
    req.start = (state == ogne_pkg::S_CROSS) ||
                (state == ogne_pkg::S_FINAL && !sum_zero);
    if (state == ogne_pkg::S_CROSS) begin
      req.vec_x = VB'(prod[0]) - VB'(prod[1]);
      req.vec_y = VB'(prod[2]) - VB'(prod[3]);
      req.vec_z = VB'(prod[4]) - VB'(prod[5]);
    end else begin
      req.vec_x = VB'(sum_x);
      req.vec_y = VB'(sum_y);
      req.vec_z = VB'(sum_z);
    end
  end

  ogne_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ogne_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and input stall.
  always_comb begin
    state_next = state;
    in_stall   = (state != ogne_pkg::S_IDLE);
    case (state)
      ogne_pkg::S_IDLE: begin
        if (accept) state_next = ogne_pkg::S_LOAD;
      end
      ogne_pkg::S_LOAD: begin
        if (!emit_q) begin
          state_next = ogne_pkg::S_IDLE;
        end else if (!win[5].point_valid) begin
          state_next = ogne_pkg::S_OUT;
        end else begin
          state_next = ogne_pkg::S_PAIR;
        end
      end
      ogne_pkg::S_PAIR: begin
        if (pair_ok) begin
          state_next = ogne_pkg::S_MUL;
        end else if (k == 3'd7) begin
          state_next = ogne_pkg::S_FINAL;
        end
      end
      ogne_pkg::S_MUL: begin
        if (mcnt == 3'd5) state_next = ogne_pkg::S_CROSS;
      end
      ogne_pkg::S_CROSS: state_next = ogne_pkg::S_UNIT;
      ogne_pkg::S_UNIT: begin
        if (rsp.done) begin
          state_next = (k == 3'd7) ? ogne_pkg::S_FINAL : ogne_pkg::S_PAIR;
        end
      end
      ogne_pkg::S_FINAL: begin
        state_next = sum_zero ? ogne_pkg::S_OUT : ogne_pkg::S_FUNIT;
      end
      ogne_pkg::S_FUNIT: begin
        if (rsp.done) state_next = ogne_pkg::S_OUT;
      end
      ogne_pkg::S_OUT: begin
        if (slot_free) state_next = ogne_pkg::S_IDLE;
      end
      default: state_next = ogne_pkg::S_IDLE;
    endcase
  end

  // Window shift on each new point.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (state == ogne_pkg::S_LOAD) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]     <= win[r*3 + 1];
        win[r*3 + 1] <= win[r*3 + 2];
      end
      win[2] <= upper_q;
      win[5] <= middle_q;
      win[8] <= nc;
    end
  end

  // Pair loop, cross products and running sum.
  always_ff @(posedge clk) begin
    case (state)
      ogne_pkg::S_LOAD: begin
        k     <= '0;
        sum_x <= '0;
        sum_y <= '0;
        sum_z <= '0;
        res_x <= '0;
        res_y <= '0;
        res_z <= '0;
        has_q <= 1'b0;
      end
      ogne_pkg::S_PAIR: begin
        if (pair_ok) begin
          ax   <= ogne_pkg::sdiff(qa.point_x, ctr.point_x);
          ay   <= ogne_pkg::sdiff(qa.point_y, ctr.point_y);
          az   <= ogne_pkg::sdiff(qa.point_z, ctr.point_z);
          bx   <= ogne_pkg::sdiff(qb.point_x, ctr.point_x);
          by   <= ogne_pkg::sdiff(qb.point_y, ctr.point_y);
          bz   <= ogne_pkg::sdiff(qb.point_z, ctr.point_z);
          mcnt <= '0;
        end else begin
          k <= k + 3'd1;
        end
      end
      ogne_pkg::S_MUL: begin
        prod[mcnt] <= mul_a * mul_b;
        mcnt       <= mcnt + 3'd1;
      end
      ogne_pkg::S_UNIT: begin
        if (rsp.done) begin
          sum_x <= sum_x + SB'(rsp.unit_x);
          sum_y <= sum_y + SB'(rsp.unit_y);
          sum_z <= sum_z + SB'(rsp.unit_z);
          k     <= k + 3'd1;
        end
      end
      ogne_pkg::S_FUNIT: begin
        if (rsp.done) begin
          res_x <= ogne_pkg::to_out(rsp.unit_x);
          res_y <= ogne_pkg::to_out(rsp.unit_y);
          res_z <= ogne_pkg::to_out(rsp.unit_z);
          has_q <= 1'b1;
        end
      end
      default: begin
        mcnt <= mcnt;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ogne_pkg::S_OUT && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ogne_pkg::S_OUT && slot_free) begin
      out_data.normal_x   <= res_x;
      out_data.normal_y   <= res_y;
      out_data.normal_z   <= res_z;
      out_data.has_normal <= has_q;
      out_data.normal_row <= res_row;
      out_data.normal_col <= res_col;
      out_data.frame_last <= last_q;
    end
  end

endmodule

[sv/ogne_line_buf.sv]
// ----------------------------------------------------------------------------
// ogne_line_buf: the two line buffers of the raster window
// Reads the upper and middle entries of one column into registers, then
// rotates that column: the middle entry moves up and the new point takes
// its place.
// ----------------------------------------------------------------------------
module ogne_line_buf (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [ogne_pkg::ADDR_BITS-1:0] rd_addr,
  input  logic                           wr_en,
  input  logic [ogne_pkg::ADDR_BITS-1:0] wr_addr,
  input  ogne_pkg::point_t               wr_point,
  output ogne_pkg::point_t               upper_q,
  output ogne_pkg::point_t               middle_q
);

  ogne_pkg::point_t upper_mem  [ogne_pkg::MAX_WIDTH];
  ogne_pkg::point_t middle_mem [ogne_pkg::MAX_WIDTH];

  // Registered reads of both rows of the column.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_q  <= upper_mem[rd_addr];
      middle_q <= middle_mem[rd_addr];
    end
  end

  // Column rotation; the write follows the read of the same column.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= middle_q;
      middle_mem[wr_addr] <= wr_point;
    end
  end

endmodule

[sv/ogne_unit.sv]
// ----------------------------------------------------------------------------
// ogne_unit: multi-cycle vector normalizer
// Scales a signed 3-vector so its largest magnitude lies in [2^29, 2^30),
// takes the floor square root of the sum of squares and divides each
// component by it, giving a unit vector with 30 fraction bits.
// ----------------------------------------------------------------------------
module ogne_unit (
  input  logic                clk,
  input  logic                rst,
  input  ogne_pkg::unit_req_t req,
  output ogne_pkg::unit_rsp_t rsp
);

  localparam int MB = ogne_pkg::VEC_BITS;
  localparam int FB = ogne_pkg::FRAC_BITS;
  localparam int UB = ogne_pkg::UNIT_BITS;

  ogne_pkg::unit_state_t state, state_next;

  logic [MB-1:0]     m0, m1, m2;
  logic [2:0]        neg;
  logic [MB-1:0]     mag0, mag1, mag2, m_or;
  logic [1:0]        sq_cnt;
  logic [FB-1:0]     sq_op;
  logic [2*FB-1:0]   sq_prod;
  logic [2*FB+1:0]   n2;
  logic [2*FB+1:0]   rt_n;
  logic [2*FB+2:0]   rt_res, rt_bit, rt_trial, rt_res_next;
  logic              rt_ge;
  logic [4:0]        rt_pos;
  logic [FB:0]       dvsr;
  logic [FB+1:0]     rem, rem_sub;
  logic              div_ge;
  logic [FB:0]       quo, quo_next;
  logic [4:0]        div_cnt;
  logic [1:0]        div_idx;
  logic [FB:0]       div_init;
  logic [UB-1:0]     quo_signed;
  logic              done;
  logic signed [UB-1:0] u0, u1, u2;
  logic              is_zero;

  // Magnitudes of the incoming vector.
  assign mag0    = req.vec_x[MB-1] ? (~req.vec_x + 1'b1) : req.vec_x;
  assign mag1    = req.vec_y[MB-1] ? (~req.vec_y + 1'b1) : req.vec_y;
  assign mag2    = req.vec_z[MB-1] ? (~req.vec_z + 1'b1) : req.vec_z;
  assign is_zero = (mag0 == '0) && (mag1 == '0) && (mag2 == '0);
  assign m_or    = m0 | m1 | m2;

  // Square operand for the current step.
  always_comb begin
    case (sq_cnt)
      2'd0:    sq_op = m0[FB-1:0];
      2'd1:    sq_op = m1[FB-1:0];
      default: sq_op = m2[FB-1:0];
    endcase
  end

  // One digit of the restoring square root.
  assign rt_bit      = (2*FB+3)'(1) << {rt_pos, 1'b0};
  assign rt_trial    = rt_res + rt_bit;
  assign rt_ge       = {1'b0, rt_n} >= rt_trial;
  assign rt_res_next = rt_ge ? ((rt_res >> 1) + rt_bit) : (rt_res >> 1);

  // One quotient bit of the restoring divider.
  assign div_ge     = rem >= {1'b0, dvsr};
  assign rem_sub    = div_ge ? (rem - {1'b0, dvsr}) : rem;
  assign quo_next   = {quo[FB-1:0], div_ge};
  assign quo_signed = neg[div_idx] ? (~UB'(quo_next) + 1'b1) : UB'(quo_next);

  // Dividend of the next component.
  always_comb begin
    case (div_idx)
      2'd0:    div_init = m1[FB:0];
      default: div_init = m2[FB:0];
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ogne_pkg::U_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ogne_pkg::U_IDLE: begin
        if (req.start && !is_zero) state_next = ogne_pkg::U_NORM;
      end
      ogne_pkg::U_NORM: begin
        if (m_or[MB-1:FB] == '0 && m_or[FB-1]) state_next = ogne_pkg::U_SQ;
      end
      ogne_pkg::U_SQ: begin
        if (sq_cnt == 2'd3) state_next = ogne_pkg::U_SQRT;
      end
      ogne_pkg::U_SQRT: begin
        if (rt_pos == '0) state_next = ogne_pkg::U_DIV;
      end
      ogne_pkg::U_DIV: begin
        if (div_cnt == 5'(FB) && div_idx == 2'd2) state_next = ogne_pkg::U_IDLE;
      end
      default: state_next = ogne_pkg::U_IDLE;
    endcase
  end

  // Done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ogne_pkg::U_IDLE && req.start && is_zero) ||
              (state == ogne_pkg::U_DIV && div_cnt == 5'(FB) && div_idx == 2'd2);
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ogne_pkg::U_IDLE: begin
        if (req.start) begin
          m0  <= mag0;
          m1  <= mag1;
          m2  <= mag2;
          neg <= {req.vec_z[MB-1], req.vec_y[MB-1], req.vec_x[MB-1]};
          if (is_zero) begin
            u0 <= '0;
            u1 <= '0;
            u2 <= '0;
          end
        end
        sq_cnt <= '0;
        n2     <= '0;
      end
      ogne_pkg::U_NORM: begin
        // Shift one place a cycle until the largest magnitude is in range.
        if (m_or[MB-1:FB] != '0) begin
          m0 <= m0 >> 1;
          m1 <= m1 >> 1;
          m2 <= m2 >> 1;
        end else if (!m_or[FB-1]) begin
          m0 <= m0 << 1;
          m1 <= m1 << 1;
          m2 <= m2 << 1;
        end
      end
      ogne_pkg::U_SQ: begin
        // Multiply, then accumulate the product in the next cycle.
        sq_prod <= sq_op * sq_op;
        if (sq_cnt != 2'd0) n2 <= n2 + (2*FB+2)'(sq_prod);
        sq_cnt <= sq_cnt + 2'd1;
        rt_n   <= n2 + (2*FB+2)'(sq_prod);
        rt_res <= '0;
        rt_pos <= 5'd31;
      end
      ogne_pkg::U_SQRT: begin
        if (rt_ge) rt_n <= rt_n - rt_trial[2*FB+1:0];
        rt_res  <= rt_res_next;
        rt_pos  <= rt_pos - 5'd1;
        dvsr    <= rt_res_next[FB:0];
        rem     <= (FB+2)'(m0[FB:0]);
        quo     <= '0;
        div_cnt <= '0;
        div_idx <= '0;
      end
      ogne_pkg::U_DIV: begin
        if (div_cnt == 5'(FB)) begin
          case (div_idx)
            2'd0:    u0 <= $signed(quo_signed);
            2'd1:    u1 <= $signed(quo_signed);
            default: u2 <= $signed(quo_signed);
          endcase
          rem     <= (FB+2)'(div_init);
          quo     <= '0;
          div_cnt <= '0;
          div_idx <= div_idx + 2'd1;
        end else begin
          rem     <= rem_sub << 1;
          quo     <= quo_next;
          div_cnt <= div_cnt + 5'd1;
        end
      end
      default: begin
        sq_cnt <= '0;
      end
    endcase
  end

  assign rsp.done   = done;
  assign rsp.unit_x = u0;
  assign rsp.unit_y = u1;
  assign rsp.unit_z = u2;

endmodule

[sv/ogne_checker.sv]
// ----------------------------------------------------------------------------
// ogne_checker: port-level checks for organized grid normal estimation
// Watches the top-level ports and flags beats that break the block's rules.
// ----------------------------------------------------------------------------
module ogne_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input ogne_pkg::normal_t out_data
);

  // A waiting result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // One point at a time: the block is busy the cycle after taking a point.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("point taken while the previous one is in work");

  // No result beat right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

  // A beat without a normal carries a zero vector.
  a_zero_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.has_normal |->
      out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
    else $error("nonzero normal on a beat without a normal");

  // Components saturate symmetrically; the most negative code never shows.
  a_saturation: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      out_data.normal_x != {1'b1, {(ogne_pkg::NORMAL_BITS-1){1'b0}}} &&
      out_data.normal_y != {1'b1, {(ogne_pkg::NORMAL_BITS-1){1'b0}}} &&
      out_data.normal_z != {1'b1, {(ogne_pkg::NORMAL_BITS-1){1'b0}}})
    else $error("normal component outside the symmetric range");

endmodule

bind organized_grid_normal_estimation ogne_checker u_ogne_checker (.*);

[sim/organized_grid_normal_estimation_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// organized_grid_normal_estimation_tb: self-checking bench for grid normals
// Streams raster point frames through the block, predicts every interior
// normal with a fixed-point software model, and compares each output beat
// field by field in arrival order. Frames are always sent complete, so the
// grid size is changed only between frames while the block is idle.
// ----------------------------------------------------------------------------
module organized_grid_normal_estimation_tb;

  localparam int     COORD_BITS     = ogne_pkg::COORD_BITS;
  localparam int     NORMAL_BITS    = ogne_pkg::NORMAL_BITS;
  localparam int     ADDR_BITS      = ogne_pkg::ADDR_BITS;
  localparam int     DIM_BITS       = ogne_pkg::DIM_BITS;
  localparam int     CFG_INDEX_BITS = ogne_pkg::CFG_INDEX_BITS;
  localparam int     MAX_WIDTH      = ogne_pkg::MAX_WIDTH;
  localparam int     MAX_HEIGHT     = ogne_pkg::MAX_HEIGHT;
  localparam longint CYCLE_LIMIT    = 6_000_000;
  localparam longint COORD_MAX      = (64'sd1 <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN      = -(64'sd1 <<< (COORD_BITS - 1));
  localparam int     RING [8]       = '{1, 0, 3, 6, 7, 8, 5, 2};

  typedef struct {
    longint x;
    longint y;
    longint z;
    bit     v;
  } grid_cell_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  ogne_pkg::point_t          in_data;
  logic                      out_valid;
  logic                      out_stall;
  ogne_pkg::normal_t         out_data;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [DIM_BITS-1:0]       cfg_data;

  // Shadow of the block state used by the normal predictor.
  grid_cell_t upper_row [MAX_WIDTH];
  grid_cell_t middle_row [MAX_WIDTH];
  grid_cell_t win [9];
  int         col_cnt;
  int         row_cnt;
  int         width_reg;
  int         height_reg;

  ogne_pkg::normal_t expected_normals [$];
  int      mismatches;
  longint  cycle_cnt;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      hold_cycles;
  int      items_sent;

  organized_grid_normal_estimation dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point normal predictor
  // ---------------------------------------------------------------------------

  function automatic bit [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit [63:0] int_sqrt(input bit [63:0] n);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Unit vector with 30 fraction bits; the zero vector stays zero.
  function automatic void unit_vector(input longint v [3], output longint o [3]);
    bit [63:0] m [3];
    bit [63:0] mx;
    bit [63:0] n2;
    bit [63:0] nrm;
    int        l;
    mx = 0;
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = magnitude(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      o = '{0, 0, 0};
      return;
    end
    l = 0;
    while (mx != 0) begin
      l++;
      mx = mx >> 1;
    end
    for (int i = 0; i < 3; i++) begin
      if (l > 30) m[i] = m[i] >> (l - 30);
      else m[i] = m[i] << (30 - l);
      n2 = n2 + m[i] * m[i];
    end
    nrm = int_sqrt(n2);
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'((m[i] << 30) / nrm);
      if (v[i] < 0) o[i] = -o[i];
    end
  endfunction

  // Round half away from zero to Q1.15 and saturate the magnitude.
  function automatic logic signed [NORMAL_BITS-1:0] round_q15(input longint u);
    bit [63:0] m;
    m = (magnitude(u) + (64'd1 << (ogne_pkg::OUT_SHIFT - 1))) >> ogne_pkg::OUT_SHIFT;
    if (m > ogne_pkg::NORM_LIM) m = ogne_pkg::NORM_LIM;
    return (u < 0) ? -NORMAL_BITS'(m) : NORMAL_BITS'(m);
  endfunction

  function automatic int clamp_dim(input int v, input int mx);
    if (v < 3) return 3;
    return (v > mx) ? mx : v;
  endfunction

  // Advance the shadow grid by one point and give the normal it completes.
  function automatic void predict_normal(input ogne_pkg::point_t p, output bit emit,
                                         output ogne_pkg::normal_t n);
    int         w;
    int         h;
    int         idx;
    bit         last_col;
    bit         last_row;
    grid_cell_t nc;
    longint     sum [3];
    longint     a [3];
    longint     b [3];
    longint     cr [3];
    longint     u [3];
    grid_cell_t qa;
    grid_cell_t qb;
    w        = clamp_dim(width_reg, MAX_WIDTH);
    h        = clamp_dim(height_reg, MAX_HEIGHT);
    idx      = col_cnt % MAX_WIDTH;
    last_col = col_cnt >= w - 1;
    last_row = row_cnt >= h - 1;
    nc       = '{longint'(p.point_x), longint'(p.point_y), longint'(p.point_z),
                 p.point_valid};

    // Shift the window left and load the new right-hand column.
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2]          = upper_row[idx];
    win[5]          = middle_row[idx];
    win[8]          = nc;
    upper_row[idx]  = middle_row[idx];
    middle_row[idx] = nc;

    emit = (row_cnt >= 2) && (col_cnt >= 2);
    n    = '0;
    if (emit) begin
      sum = '{0, 0, 0};
      if (win[4].v) begin
        for (int k = 0; k < 8; k++) begin
          qa = win[RING[k]];
          qb = win[RING[(k+1)%8]];
          if (qa.v && qb.v) begin
            a = '{qa.x - win[4].x, qa.y - win[4].y, qa.z - win[4].z};
            b = '{qb.x - win[4].x, qb.y - win[4].y, qb.z - win[4].z};
            cr[0] = a[1]*b[2] - a[2]*b[1];
            cr[1] = a[2]*b[0] - a[0]*b[2];
            cr[2] = a[0]*b[1] - a[1]*b[0];
            unit_vector(cr, u);
            for (int i = 0; i < 3; i++) sum[i] += u[i];
          end
        end
        if (sum[0] != 0 || sum[1] != 0 || sum[2] != 0) begin
          unit_vector(sum, u);
          n.normal_x   = round_q15(u[0]);
          n.normal_y   = round_q15(u[1]);
          n.normal_z   = round_q15(u[2]);
          n.has_normal = 1'b1;
        end
      end
      n.normal_row = ADDR_BITS'(row_cnt - 1);
      n.normal_col = ADDR_BITS'(col_cnt - 1);
      n.frame_last = last_col && last_row;
    end

    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one point beat, wait for its acceptance and queue its normal.
  task automatic send_point(input ogne_pkg::point_t p);
    bit                emit;
    ogne_pkg::normal_t n;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    predict_normal(p, emit, n);
    if (emit) expected_normals = {expected_normals, n};
    items_sent++;
  endtask

  // Wait until every queued normal has arrived and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= DIM_BITS'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (index == ogne_pkg::REG_GRID_WIDTH) width_reg = value & 'h7FF;
    else height_reg = value & 'h7FF;
  endtask

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    return COORD_BITS'($urandom);
  endfunction

  // Style 0: noisy smooth surface, mostly valid. Style 1: full-range random.
  // Style 2: sparse valid points.
  function automatic ogne_pkg::point_t make_point(input int style, input int r,
                                                  input int c);
    ogne_pkg::point_t p;
    case (style)
      0: begin
        p.point_x     = COORD_BITS'(c * 6000 + $urandom_range(0, 3000) - 1500);
        p.point_y     = COORD_BITS'(r * 6000 + $urandom_range(0, 3000) - 1500);
        p.point_z     = COORD_BITS'(65536 + $urandom_range(0, 40000) - 20000);
        p.point_valid = $urandom_range(99) < 88;
      end
      1: begin
        p.point_x     = rand_coord();
        p.point_y     = rand_coord();
        p.point_z     = rand_coord();
        p.point_valid = $urandom_range(99) < 70;
      end
      default: begin
        p.point_x     = rand_coord();
        p.point_y     = rand_coord();
        p.point_z     = rand_coord();
        p.point_valid = $urandom_range(15) == 0;
      end
    endcase
    return p;
  endfunction

  // Program the grid size and send one whole frame of generated points.
  task automatic send_frame(input int w_val, input int h_val, input int style);
    int w;
    int h;
    wait_idle();
    write_reg(ogne_pkg::REG_GRID_WIDTH, w_val);
    write_reg(ogne_pkg::REG_GRID_HEIGHT, h_val);
    w = clamp_dim(w_val, MAX_WIDTH);
    h = clamp_dim(h_val, MAX_HEIGHT);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) send_point(make_point(style, r, c));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Coordinate extremes, a collinear frame and a lone valid centre.
  task automatic test_directed();
    ogne_pkg::point_t p;
    longint           pick [3];
    pick = '{COORD_MAX, COORD_MIN, 0};
    wait_idle();
    write_reg(ogne_pkg::REG_GRID_WIDTH, 3);
    write_reg(ogne_pkg::REG_GRID_HEIGHT, 3);
    // Extreme coordinates on every axis around a valid centre.
    for (int i = 0; i < 9; i++) begin
      p.point_x     = COORD_BITS'(pick[i % 3]);
      p.point_y     = COORD_BITS'(pick[(i / 3) % 3]);
      p.point_z     = COORD_BITS'(pick[(i + 1) % 3]);
      p.point_valid = 1'b1;
      send_point(p);
    end
    // All points on one line, so every cross product is zero.
    for (int i = 0; i < 9; i++) begin
      p.point_x     = COORD_BITS'((i % 3 + 3 * (i / 3)) * 1000);
      p.point_y     = '0;
      p.point_z     = '0;
      p.point_valid = 1'b1;
      send_point(p);
    end
    // Only the centre is valid: the sum stays zero.
    for (int i = 0; i < 9; i++) begin
      p.point_x     = rand_coord();
      p.point_y     = rand_coord();
      p.point_z     = rand_coord();
      p.point_valid = (i == 4);
      send_point(p);
    end
  endtask

  // Register values below the smallest grid size on both dimensions.
  task automatic test_dimension_extremes();
    send_frame(2, 1, 1);
    send_frame(0, 0, 1);
  endtask

  task automatic test_random_frames(input int send_pct, input int recv_pct,
                                    input int target);
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start         = items_sent;
    while (items_sent - start < target) begin
      send_frame($urandom_range(3, 8), $urandom_range(3, 7), $urandom_range(0, 3) == 0);
    end
  endtask

  // The receiver holds off for a long stretch while points keep coming.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_idle();
    hold_cycles = 3000;
    send_frame(5, 5, 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // Receiver stall: a long hold when requested, else random idling.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= $urandom_range(99) < recv_idle_pct;
    end
  end

  // Compare each accepted normal beat with the oldest prediction.
  always @(posedge clk) begin
    ogne_pkg::normal_t exp_n;
    if (!rst && out_valid && !out_stall) begin
      if (expected_normals.size() == 0) begin
        $error("unexpected normal beat at row %0d col %0d",
               out_data.normal_row, out_data.normal_col);
        mismatches++;
      end else begin
        exp_n = expected_normals.pop_front();
        if (out_data.normal_x !== exp_n.normal_x) begin
          $error("normal_x: expected %0d, got %0d", exp_n.normal_x, out_data.normal_x);
          mismatches++;
        end
        if (out_data.normal_y !== exp_n.normal_y) begin
          $error("normal_y: expected %0d, got %0d", exp_n.normal_y, out_data.normal_y);
          mismatches++;
        end
        if (out_data.normal_z !== exp_n.normal_z) begin
          $error("normal_z: expected %0d, got %0d", exp_n.normal_z, out_data.normal_z);
          mismatches++;
        end
        if (out_data.has_normal !== exp_n.has_normal) begin
          $error("has_normal: expected %0d, got %0d", exp_n.has_normal,
                 out_data.has_normal);
          mismatches++;
        end
        if (out_data.normal_row !== exp_n.normal_row) begin
          $error("normal_row: expected %0d, got %0d", exp_n.normal_row,
                 out_data.normal_row);
          mismatches++;
        end
        if (out_data.normal_col !== exp_n.normal_col) begin
          $error("normal_col: expected %0d, got %0d", exp_n.normal_col,
                 out_data.normal_col);
          mismatches++;
        end
        if (out_data.frame_last !== exp_n.frame_last) begin
          $error("frame_last: expected %0d, got %0d", exp_n.frame_last,
                 out_data.frame_last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    cycle_cnt     = 0;
    mismatches    = 0;
    hold_cycles   = 0;
    items_sent    = 0;
    send_idle_pct = 15;
    recv_idle_pct = 51;
    width_reg     = 640;
    height_reg    = 480;
    col_cnt       = 0;
    row_cnt       = 0;
    foreach (win[i]) win[i] = '{0, 0, 0, 1'b0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_dimension_extremes();
    test_random_frames(15, 51, 180);
    test_random_frames(51, 15, 180);
    test_random_frames(0, 0, 180);
    test_output_backpressure();

    wait_idle();
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && expected_normals.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/ogne_pkg.sv
sv/ogne_line_buf.sv
sv/ogne_unit.sv
sv/organized_grid_normal_estimation.sv
sv/ogne_checker.sv
sim/organized_grid_normal_estimation_tb.sv
